>>> rtl/bcg_pkg.sv
// Shared types and constants for the binomial cumulative distribution generator.
`timescale 1ns / 1ps
`default_nettype none
package bcg_pkg;

    localparam int MAX_TRIALS_DEF = 63;
    localparam int FRAC_BITS_DEF  = 32;

    localparam int IDX_W     = 6;   // trial count and entry index
    localparam int NEXT_W    = 7;   // next index, may run one past the trial count
    localparam int PROB_W    = 17;  // probability in Q0.16, one included
    localparam int CDF_W     = 33;  // cumulative value port
    localparam int BINOM_W   = 66;  // C(n,k) times (n-k) before the division
    localparam int CNT_W     = 7;   // bit counter, counts up to BINOM_W - 1
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 17;

    localparam logic [PROB_W-1:0] P_ONE = PROB_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_TRIAL_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SUCCESS_PROB = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BMUL,
        S_BDIV,
        S_PMUL,
        S_TERM,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> rtl/binomial_cdf_generator.sv
// Binomial cumulative distribution generator, bit-serial datapath, top level.
// The time from acceptance to the result for entry k of n trials is set by the bit-serial
// multiply and divide for each step of C(n,k), the n serial multiplies of the power product
// and the serial saturating multiply of the term. A request past the end of the table goes
// straight to the done state. One item is in work at a time.
// Reset (synchronous, active low) clears the sum and index and sets n = 1, p = one half.
`timescale 1ns / 1ps
`default_nettype none
module binomial_cdf_generator #(
    parameter int MAX_TRIALS = bcg_pkg::MAX_TRIALS_DEF,
    parameter int FRAC_BITS  = bcg_pkg::FRAC_BITS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [bcg_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [bcg_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire                             i_valid,
    output logic                            o_ready,
    input  wire                             i_restart,
    output logic                            o_valid,
    input  wire                             i_ready,
    output logic [bcg_pkg::IDX_W-1:0]       o_entry_index,
    output logic [bcg_pkg::CDF_W-1:0]       o_cdf_value,
    output logic                            o_done_res
);
    import bcg_pkg::*;

    // The power product is Q0.FRAC_BITS and can hold exactly one.
    localparam int AW  = FRAC_BITS + 1;
    // Product of the power product by a Q0.16 probability.
    localparam int PW2 = AW + PROB_W;
    // Shifted term accumulator: twice a value up to one plus another up to one.
    localparam int TW  = FRAC_BITS + 2;

    localparam logic [AW-1:0]    ONE_A = AW'(1) << FRAC_BITS;
    localparam logic [TW-1:0]    ONE_T = TW'(1) << FRAC_BITS;
    localparam logic [CDF_W-1:0] ONE_S = CDF_W'(1) << FRAC_BITS;

    // Configuration registers.
    logic [IDX_W-1:0]  r_cfg_n;
    logic [PROB_W-1:0] r_cfg_p;

    // Sequencer and persistent state.
    t_state            r_state, n_state;
    logic [NEXT_W-1:0] r_next, n_next;
    logic [CDF_W-1:0]  r_sum, n_sum;

    // Values latched when an item is accepted.
    logic [IDX_W-1:0]  r_n, n_n;
    logic [IDX_W-1:0]  r_k, n_k;
    logic [PROB_W-1:0] r_p, n_p;
    logic [PROB_W-1:0] r_q, n_q;

    // Binomial coefficient: C(n,i+1) = C(n,i) * (n-i) / (i+1), one bit per cycle.
    logic [BINOM_W-1:0] r_c, n_c;
    logic [BINOM_W-1:0] r_bp, n_bp;
    logic [BINOM_W-1:0] r_ba, n_ba;
    logic [IDX_W-1:0]   r_bm, n_bm;
    logic [NEXT_W-1:0]  r_rm, n_rm;
    logic [NEXT_W-1:0]  r_i, n_i;

    // Power product: one serial multiply per factor of p or 1-p.
    logic [AW-1:0]     r_acc, n_acc;
    logic [PW2-1:0]    r_pr, n_pr;
    logic [PW2-1:0]    r_ma, n_ma;
    logic [PROB_W-1:0] r_mx, n_mx;
    logic [NEXT_W-1:0] r_pi, n_pi;

    // Saturating term multiply, coefficient taken most significant bit first.
    logic [TW-1:0] r_ts, n_ts;
    logic          r_sat, n_sat;

    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Result waiting to enter the output register, and the output register.
    logic [IDX_W-1:0] r_res_idx, n_res_idx;
    logic [CDF_W-1:0] r_res_cdf, n_res_cdf;
    logic             r_res_done, n_res_done;
    logic             r_ov, n_ov;
    logic [IDX_W-1:0] r_oidx, n_oidx;
    logic [CDF_W-1:0] r_ocdf, n_ocdf;
    logic             r_odone, n_odone;

    // Effective n and p: values beyond their bounds are clamped.
    logic [IDX_W-1:0]  eff_n;
    logic [PROB_W-1:0] eff_p;

    assign eff_n = (r_cfg_n > IDX_W'(MAX_TRIALS)) ? IDX_W'(MAX_TRIALS) : r_cfg_n;
    assign eff_p = (r_cfg_p > P_ONE) ? P_ONE : r_cfg_p;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n <= IDX_W'(1);
            r_cfg_p <= PROB_W'(32768);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_TRIAL_COUNT) begin
                r_cfg_n <= i_cfg_data[IDX_W-1:0];
            end else if (i_cfg_idx == REG_SUCCESS_PROB) begin
                r_cfg_p <= i_cfg_data[PROB_W-1:0];
            end
        end
    end

    always_comb begin
        logic [NEXT_W-1:0]  v_idx;
        logic [CDF_W-1:0]   v_sum;
        logic [BINOM_W-1:0] v_bp;
        logic [NEXT_W:0]    v_t;
        logic [NEXT_W:0]    v_d;
        logic               v_q;
        logic [NEXT_W-1:0]  v_inext;
        logic [PW2-1:0]     v_pr;
        logic [AW-1:0]      v_acc;
        logic [NEXT_W-1:0]  v_pnext;
        logic [TW-1:0]      v_ts;
        logic [AW-1:0]      v_term;
        logic [CDF_W:0]     v_tot;
        logic [CDF_W-1:0]   v_new;

        v_idx   = '0;
        v_sum   = '0;
        v_bp    = '0;
        v_t     = '0;
        v_d     = '0;
        v_q     = 1'b0;
        v_inext = '0;
        v_pr    = '0;
        v_acc   = '0;
        v_pnext = '0;
        v_ts    = '0;
        v_term  = '0;
        v_tot   = '0;
        v_new   = '0;

        n_state    = r_state;
        n_next     = r_next;
        n_sum      = r_sum;
        n_n        = r_n;
        n_k        = r_k;
        n_p        = r_p;
        n_q        = r_q;
        n_c        = r_c;
        n_bp       = r_bp;
        n_ba       = r_ba;
        n_bm       = r_bm;
        n_rm       = r_rm;
        n_i        = r_i;
        n_acc      = r_acc;
        n_pr       = r_pr;
        n_ma       = r_ma;
        n_mx       = r_mx;
        n_pi       = r_pi;
        n_ts       = r_ts;
        n_sat      = r_sat;
        n_cnt      = r_cnt;
        n_res_idx  = r_res_idx;
        n_res_cdf  = r_res_cdf;
        n_res_done = r_res_done;
        n_oidx     = r_oidx;
        n_ocdf     = r_ocdf;
        n_odone    = r_odone;
        n_ov       = r_ov && !i_ready;

        o_ready = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    v_idx  = i_restart ? '0 : r_next;
                    v_sum  = i_restart ? '0 : r_sum;
                    n_next = v_idx;
                    n_sum  = v_sum;
                    n_n    = eff_n;
                    n_p    = eff_p;
                    n_q    = P_ONE - eff_p;
                    n_c    = BINOM_W'(1);
                    n_i    = '0;
                    n_acc  = ONE_A;
                    n_pi   = '0;
                    n_cnt  = '0;
                    if (v_idx > NEXT_W'(eff_n)) begin
                        // Past the end of the table: repeat the final entry.
                        n_res_idx  = eff_n;
                        n_res_cdf  = v_sum;
                        n_res_done = (eff_n == r_cfg_n);
                        n_state    = S_DONE;
                    end else begin
                        n_k = v_idx[IDX_W-1:0];
                        if (v_idx != '0) begin
                            n_ba    = BINOM_W'(1);
                            n_bp    = '0;
                            n_bm    = eff_n;
                            n_state = S_BMUL;
                        end else if (eff_n != '0) begin
                            // Entry zero: every factor is 1-p.
                            n_ma    = PW2'(ONE_A);
                            n_pr    = '0;
                            n_mx    = P_ONE - eff_p;
                            n_state = S_PMUL;
                        end else begin
                            n_ts    = '0;
                            n_sat   = 1'b0;
                            n_state = S_TERM;
                        end
                    end
                end
            end

            S_BMUL: begin
                v_bp  = r_bm[0] ? (r_bp + r_ba) : r_bp;
                n_bp  = v_bp;
                n_ba  = r_ba << 1;
                n_bm  = r_bm >> 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(IDX_W - 1)) begin
                    n_cnt   = '0;
                    n_rm    = '0;
                    n_state = S_BDIV;
                end
            end

            S_BDIV: begin
                // Restoring division by i+1, one quotient bit per cycle.
                v_t = {r_rm, r_bp[BINOM_W-1]};
                v_d = (NEXT_W + 1)'(r_i) + (NEXT_W + 1)'(1);
                if (v_t >= v_d) begin
                    n_rm = NEXT_W'(v_t - v_d);
                    v_q  = 1'b1;
                end else begin
                    n_rm = v_t[NEXT_W-1:0];
                    v_q  = 1'b0;
                end
                v_bp  = {r_bp[BINOM_W-2:0], v_q};
                n_bp  = v_bp;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(BINOM_W - 1)) begin
                    v_inext = r_i + NEXT_W'(1);
                    n_c     = v_bp;
                    n_i     = v_inext;
                    n_cnt   = '0;
                    if (v_inext == NEXT_W'(r_k)) begin
                        if (r_n != '0) begin
                            n_ma    = PW2'(r_acc);
                            n_pr    = '0;
                            n_mx    = (r_k != '0) ? r_p : r_q;
                            n_state = S_PMUL;
                        end else begin
                            n_ts    = '0;
                            n_sat   = 1'b0;
                            n_state = S_TERM;
                        end
                    end else begin
                        n_ba    = v_bp;
                        n_bp    = '0;
                        n_bm    = r_n - v_inext[IDX_W-1:0];
                        n_state = S_BMUL;
                    end
                end
            end

            S_PMUL: begin
                v_pr  = r_mx[0] ? (r_pr + r_ma) : r_pr;
                n_pr  = v_pr;
                n_ma  = r_ma << 1;
                n_mx  = r_mx >> 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(PROB_W - 1)) begin
                    v_acc   = v_pr[16 +: AW];
                    v_pnext = r_pi + NEXT_W'(1);
                    n_acc   = v_acc;
                    n_pi    = v_pnext;
                    n_cnt   = '0;
                    if (v_pnext == NEXT_W'(r_n)) begin
                        n_ts    = '0;
                        n_sat   = 1'b0;
                        n_state = S_TERM;
                    end else begin
                        n_ma = PW2'(v_acc);
                        n_pr = '0;
                        n_mx = (v_pnext < NEXT_W'(r_k)) ? r_p : r_q;
                    end
                end
            end

            S_TERM: begin
                v_ts  = {r_ts[TW-2:0], 1'b0}
                        + (r_c[BINOM_W-1] ? TW'(r_acc) : TW'(0));
                n_c   = r_c << 1;
                n_cnt = r_cnt + CNT_W'(1);
                if (!r_sat) begin
                    n_ts = v_ts;
                    if (v_ts > ONE_T) begin
                        n_sat = 1'b1;
                    end
                end
                if (r_cnt == CNT_W'(BINOM_W - 1)) begin
                    v_term     = (r_sat || (v_ts > ONE_T)) ? ONE_A : v_ts[AW-1:0];
                    v_tot      = (CDF_W + 1)'(r_sum) + (CDF_W + 1)'(v_term);
                    v_new      = (v_tot > (CDF_W + 1)'(ONE_S)) ? ONE_S
                                                               : v_tot[CDF_W-1:0];
                    n_sum      = v_new;
                    n_next     = NEXT_W'(r_k) + NEXT_W'(1);
                    n_res_idx  = r_k;
                    n_res_cdf  = v_new;
                    n_res_done = (r_k == r_cfg_n);
                    n_cnt      = '0;
                    n_state    = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_oidx  = r_res_idx;
                    n_ocdf  = r_res_cdf;
                    n_odone = r_res_done;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_next  <= '0;
            r_sum   <= '0;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_next  <= n_next;
            r_sum   <= n_sum;
            r_ov    <= n_ov;
            r_cnt   <= n_cnt;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_k        <= n_k;
        r_p        <= n_p;
        r_q        <= n_q;
        r_c        <= n_c;
        r_bp       <= n_bp;
        r_ba       <= n_ba;
        r_bm       <= n_bm;
        r_rm       <= n_rm;
        r_i        <= n_i;
        r_acc      <= n_acc;
        r_pr       <= n_pr;
        r_ma       <= n_ma;
        r_mx       <= n_mx;
        r_pi       <= n_pi;
        r_ts       <= n_ts;
        r_sat      <= n_sat;
        r_res_idx  <= n_res_idx;
        r_res_cdf  <= n_res_cdf;
        r_res_done <= n_res_done;
        r_oidx     <= n_oidx;
        r_ocdf     <= n_ocdf;
        r_odone    <= n_odone;
    end

    assign o_valid       = r_ov;
    assign o_entry_index = r_oidx;
    assign o_cdf_value   = r_ocdf;
    assign o_done_res    = r_odone;

`ifndef SYNTH
    // The running sum never exceeds one.
    a_sum_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= ONE_S)
        else $error("running sum above one");

    // An accepted item always starts work or a repeat of the final entry.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state != S_IDLE))
        else $error("accepted item left the sequencer idle");

    // A delivered result flagged as the final one carries the trial count as its index.
    a_done_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (o_entry_index == r_cfg_n))
        else $error("final entry flagged at the wrong index");
`endif

endmodule
`default_nettype wire
